/* sv/ctirt_pkg.sv */
// Shared types and constants of the level-order tree table.
`default_nettype none
package ctirt_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 6;
  localparam int ENT_W      = 7;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;      // capture input beat, restart scan
    logic    ins;       // write value at the slot after the tail, raise count
    logic    scan;      // issue next scan read, compare previous one
    logic    hit;       // latch matched slot, read the tail value
    logic    rem;       // write tail value over matched slot, lower count
    logic    clr_slot;  // result slot reads zero
    logic    st_load;
    status_t st;
    logic    res_load;  // move result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic match;
    logic scan_end;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* sv/ctirt_ctrl.sv */
// Controller state machine of the level-order tree table.
`default_nettype none
module ctirt_ctrl
  import ctirt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_action,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (action_t'(in_action) == ACT_REMOVE) ? S_SCAN : S_INSERT;
        end
      end
      S_INSERT: state_nxt = S_DONE;
      S_SCAN: begin
        priority if (sts.match) begin
          state_nxt = S_WRITE;
        end else if (sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.st    = ST_INSERTED;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_INSERT: begin
        cmd.st_load = 1'b1;
        if (sts.full) begin
          cmd.st       = ST_FULL;
          cmd.clr_slot = 1'b1;
        end else begin
          cmd.st  = ST_INSERTED;
          cmd.ins = 1'b1;
        end
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.hit = 1'b1;
        end else if (sts.scan_end) begin
          cmd.st_load  = 1'b1;
          cmd.st       = ST_NOT_FOUND;
          cmd.clr_slot = 1'b1;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.rem     = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st      = ST_REMOVED;
      end
      S_DONE: begin
        cmd.res_load = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/ctirt_dp.sv */
// Datapath of the level-order tree table: value store, count, scan and result register.
`default_nettype none
module ctirt_dp
  import ctirt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_value,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [SLOT_W-1:0]          out_slot,
  output logic [ENT_W-1:0]           out_entries
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          idx_r;
  logic                   rd_ok_r;
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]          rd_slot_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [AW-1:0]          res_slot_r;
  status_t                st_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [ENT_W-1:0]       out_entries_r;

  logic [AW-1:0] tail_slot;
  logic          more;

  assign tail_slot = AW'(cnt_r - CW'(1));
  assign more      = (idx_r < cnt_r);

  assign sts.full     = (cnt_r == CW'(CAPACITY));
  assign sts.match    = rd_ok_r && (rd_data_r == val_r);
  assign sts.scan_end = !rd_ok_r && !more;
  assign sts.out_busy = out_valid_r && !out_tready;

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      mem[cnt_r[AW-1:0]] <= val_r;
    end else if (cmd.rem) begin
      mem[res_slot_r] <= rd_data_r;
    end
    if (cmd.hit) begin
      rd_data_r <= mem[tail_slot];
    end else if (cmd.scan && more) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.rem) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.load || cmd.hit) begin
        rd_ok_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_ok_r <= more;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= VALUE_WIDTH'(in_value);
      idx_r <= '0;
    end else if (cmd.scan && more) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.scan) begin
      rd_slot_r <= idx_r[AW-1:0];
    end
    if (cmd.ins) begin
      res_slot_r <= cnt_r[AW-1:0];
    end else if (cmd.hit) begin
      res_slot_r <= rd_slot_r;
    end else if (cmd.clr_slot) begin
      res_slot_r <= '0;
    end
    if (cmd.st_load) begin
      st_r <= cmd.st;
    end
    if (cmd.res_load) begin
      out_status_r  <= st_r;
      out_slot_r    <= SLOT_W'(res_slot_r);
      out_entries_r <= ENT_W'(cnt_r);
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_entries = out_entries_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_raises: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not raise the count");

  a_rem_lowers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("remove did not lower the count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !(out_valid_r && !out_tready))
    else $error("result loaded over an untaken beat");
`endif

endmodule
`default_nettype wire

/* sv/complete_tree_insert_remove_table.sv */
// Top level of the level-order tree table: stream ports, controller and datapath.
// A complete binary tree held in level order: insert appends a value at slot
// "entries", remove finds the first equal value in slot order, overwrites it with
// the tail value and shrinks the count. Every input beat gives one result beat.
// A remove scans the single-port value store one slot per cycle, then reads the
// tail value and writes it back over the matched slot.
// One item is worked on at a time; the next input beat is taken as soon as the
// result sits in the output register, even if it has not yet been taken.
`default_nettype none
module complete_tree_insert_remove_table
  import ctirt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  wire logic                  in_tuser,   // [0] action
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [5:0] slot, [12:6] entries, [15:13] zero
  output logic [STATUS_W-1:0]        out_tuser   // [1:0] status
);

  cmd_t cmd;
  sts_t sts;

  logic [SLOT_W-1:0] out_slot;
  logic [ENT_W-1:0]  out_entries;

  ctirt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctirt_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (out_tuser),
    .out_slot    (out_slot),
    .out_entries (out_entries)
  );

  assign out_tdata = {(OUT_DATA_W - SLOT_W - ENT_W)'(0), out_entries, out_slot};

endmodule
`default_nettype wire

/* test/tb_complete_tree_insert_remove_table.sv */
// Self-checking testbench for the level-order tree table: directed and random insert/remove.
`timescale 1ns / 100ps
module tb_complete_tree_insert_remove_table;
  import ctirt_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_TARGET = 2000;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  entries;
  } tree_result_t;

  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIX
  } phase_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Shadow of the tree: level-order slots and fill count
  logic [VALUE_WIDTH-1:0] shadow_slots [CAPACITY];
  int                     shadow_count;
  tree_result_t           pending_results[$];

  int  error_count;
  int  items_sent;
  int  quiet_cycles;
  int  sink_hold;
  bit  gaps_on;

  complete_tree_insert_remove_table #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 15);
    if (r == 4) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  // Apply one operation to the shadow tree and return what the block must answer
  function automatic tree_result_t apply_tree_op(action_t act, logic [31:0] val);
    tree_result_t res;
    logic [VALUE_WIDTH-1:0] key;
    bit hit;
    key = val[VALUE_WIDTH-1:0];
    res.slot = '0;
    hit = 1'b0;
    if (act == ACT_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        res.slot = SLOT_W'(shadow_count);
        shadow_slots[shadow_count] = key;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      for (int i = 0; i < shadow_count && !hit; i++) begin
        if (shadow_slots[i] == key) begin
          hit = 1'b1;
          res.slot = SLOT_W'(i);
        end
      end
      if (hit) begin
        shadow_slots[res.slot] = shadow_slots[shadow_count - 1];
        shadow_count--;
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.entries = ENT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Drive one beat, wait for the handshake, then record its expected result
  task automatic send_op(input action_t act, input logic [31:0] val);
    int gap;
    tree_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    res = apply_tree_op(act, val);
    pending_results.push_back(res);
    items_sent++;
  endtask

  // Lower valid and wait until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_remove();
    send_op(ACT_REMOVE, 32'h0);
    send_op(ACT_REMOVE, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_extreme_values();
    send_op(ACT_INSERT, 32'h0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF);
    send_op(ACT_INSERT, 32'h8000_0000);
    send_op(ACT_INSERT, 32'h0000_0001);
    send_op(ACT_REMOVE, 32'hFFFF_FFFF);   // middle slot, tail moves in
    send_op(ACT_REMOVE, 32'h8000_0000);   // now the last slot
    send_op(ACT_REMOVE, 32'h1234_5678);   // absent
    send_op(ACT_REMOVE, 32'h0000_0001);
    send_op(ACT_REMOVE, 32'h0);           // root and last slot at once
    drain();
  endtask

  task automatic test_duplicates();
    send_op(ACT_INSERT, 32'd7);
    send_op(ACT_INSERT, 32'd7);
    send_op(ACT_INSERT, 32'd9);
    send_op(ACT_INSERT, 32'd7);
    send_op(ACT_REMOVE, 32'd7);
    send_op(ACT_REMOVE, 32'd7);
    send_op(ACT_REMOVE, 32'd9);
    send_op(ACT_REMOVE, 32'd7);
    send_op(ACT_REMOVE, 32'd7);
    drain();
  endtask

  // Fill every slot, push against the full store, then empty it again
  task automatic test_full_store();
    while (shadow_count < CAPACITY) send_op(ACT_INSERT, 32'hA500_0000 + shadow_count);
    repeat (3) send_op(ACT_INSERT, rand_value());
    send_op(ACT_REMOVE, 32'h5A5A_5A5A);
    send_op(ACT_REMOVE, shadow_slots[CAPACITY - 1]);
    send_op(ACT_INSERT, $urandom);
    send_op(ACT_REMOVE, shadow_slots[0]);
    while (shadow_count > 0)
      send_op(ACT_REMOVE, shadow_slots[$urandom_range(0, shadow_count - 1)]);
    drain();
  endtask

  task automatic run_random_phase(input phase_kind_t kind, input int n);
    int ins_pct;
    action_t act;
    logic [31:0] val;
    case (kind)
      PH_GROW:   ins_pct = 85;
      PH_SHRINK: ins_pct = 15;
      default:   ins_pct = 50;
    endcase
    repeat (n) begin
      act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
      if (act == ACT_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
        val = shadow_slots[$urandom_range(0, shadow_count - 1)];
      else
        val = rand_value();
      send_op(act, val);
    end
  endtask

  task automatic test_random();
    phase_kind_t kind;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       kind = PH_GROW;
        1:       kind = PH_SHRINK;
        default: kind = PH_MIX;
      endcase
      run_random_phase(kind, $urandom_range(40, 140));
    end
    drain();
  endtask

  // Result sink: stall at random
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else begin
      sink_hold = pick_gap();
      out_tready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    tree_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tdata[SLOT_W-1:0] != want.slot)
          report_mismatch("slot", out_tdata[SLOT_W-1:0], want.slot);
        if (out_tdata[SLOT_W+ENT_W-1:SLOT_W] != want.entries)
          report_mismatch("entries", out_tdata[SLOT_W+ENT_W-1:SLOT_W], want.entries);
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    sink_hold    = 0;
    quiet_cycles = 0;
    error_count  = 0;
    items_sent   = 0;
    shadow_count = 0;
    gaps_on      = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_remove();
    test_extreme_values();
    test_duplicates();
    gaps_on = 1'b0;
    test_full_store();
    gaps_on = 1'b1;
    test_full_store();
    test_random();

    repeat (CAPACITY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("[%0t] %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ctirt_pkg.sv
sv/ctirt_ctrl.sv
sv/ctirt_dp.sv
sv/complete_tree_insert_remove_table.sv
test/tb_complete_tree_insert_remove_table.sv
